// File: rtl/core/hip_pkg.sv
// ----------------------------------------------------------------------------
// hip_pkg
// Shared widths, types and coefficient tables for the heat index pipeline.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package hip_pkg;

  localparam int HIP_T_W   = 17;
  localparam int HIP_H_W   = 15;
  localparam int HIP_HI_W  = 18;
  localparam int HIP_X_W   = 18;
  localparam int HIP_SLICE_W = 32;

  localparam int HIP_FRACTION_BITS_DEF = 8;
  localparam int HIP_COEF_FRAC = 48;
  localparam int HIP_COEF_W    = 64;
  // headroom above the coefficient and input scaling: magnitude stays below 2^14 degrees
  localparam int HIP_MAG_W     = 16;
  localparam int HIP_ACC_W_DEF = HIP_COEF_FRAC + 6 * HIP_FRACTION_BITS_DEF + HIP_MAG_W;
  localparam int HIP_LANES_DEF = 4;

  localparam int HIP_T_LO_DEG = -40;
  localparam int HIP_T_HI_DEG = 150;
  localparam int HIP_H_HI_PCT = 100;

  localparam int HIP_HI_MAX = 131071;
  localparam int HIP_HI_MIN = -131072;

  localparam int HIP_EXP_MAX   = 16;
  localparam int HIP_INT_STEPS = 32;

  typedef logic signed [HIP_T_W-1:0]  hip_temp_t;
  typedef logic        [HIP_H_W-1:0]  hip_hum_t;
  typedef logic signed [HIP_HI_W-1:0] hip_hi_t;

  // c_ij = (+/-) num / 10^exp, row i is the power of temperature, column j of humidity
  localparam int HIP_COEF_NUM [4][4] = '{
    '{16923,  537941, 728898, 291583},
    '{185212, 100254, 814971, 197483},
    '{941695, 345372, 102102, 843296},
    '{38646,  142721, 218429, 481975}
  };

  localparam int HIP_COEF_EXP [4][4] = '{
    '{3, 5, 8,  10},
    '{6, 6, 9,  12},
    '{8, 9, 10, 15},
    '{9, 11, 13, 16}
  };

  localparam logic HIP_COEF_NEG [4][4] = '{
    '{1'b0, 1'b0, 1'b0, 1'b0},
    '{1'b0, 1'b1, 1'b1, 1'b0},
    '{1'b0, 1'b0, 1'b0, 1'b0},
    '{1'b1, 1'b0, 1'b1, 1'b1}
  };

  // coefficient with 48 fraction bits, rounded to nearest, halves away from zero
  function automatic logic signed [HIP_COEF_W-1:0] hip_coef(input logic [1:0] i,
                                                            input logic [1:0] j);
    logic [HIP_COEF_W-1:0] d;
    logic [HIP_COEF_W-1:0] q;
    logic [HIP_COEF_W-1:0] r;
    d = 64'd1;
    for (int e = 0; e < HIP_EXP_MAX; e++) begin
      if (e < HIP_COEF_EXP[i][j]) d = d * 64'd10;
    end
    q = '0;
    r = 64'(HIP_COEF_NUM[i][j]);
    for (int k = 0; k < HIP_INT_STEPS; k++) begin
      if (r >= d) begin
        r = r - d;
        q = q + 64'd1;
      end
    end
    for (int e = 0; e < HIP_COEF_FRAC; e++) begin
      r = r << 1;
      q = q << 1;
      if (r >= d) begin
        r = r - d;
        q = q | 64'd1;
      end
    end
    if ((r << 1) >= d) q = q + 64'd1;
    return HIP_COEF_NEG[i][j] ? -$signed(q) : $signed(q);
  endfunction

endpackage

// File: rtl/core/hip_channel_if.sv
// ----------------------------------------------------------------------------
// hip_channel_if
// Valid/ready channels for the heat index samples and results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface hip_in_if
  import hip_pkg::*;
();
  logic      valid;
  logic      ready;
  hip_temp_t temperature;
  hip_hum_t  humidity;

  modport source (output valid, output temperature, output humidity, input ready);
  modport sink   (input valid, input temperature, input humidity, output ready);
endinterface

interface hip_out_if
  import hip_pkg::*;
();
  logic    valid;
  logic    ready;
  hip_hi_t heat_index;
  logic    saturated;

  modport source (output valid, output heat_index, output saturated, input ready);
  modport sink   (input valid, input heat_index, input saturated, output ready);
endinterface

// File: rtl/core/hip_mac.sv
// ----------------------------------------------------------------------------
// hip_mac
// One Horner step y = a * x + addend over several lanes, three stages:
// sliced partial products, partial product sum, addend.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hip_mac
  import hip_pkg::*;
#(
  parameter int LANES  = HIP_LANES_DEF,
  parameter int W      = HIP_ACC_W_DEF,
  parameter int SIDE_W = HIP_X_W
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      valid_i,
  output logic                      adv_o,
  input  logic signed [W-1:0]       a_i    [LANES],
  input  logic signed [HIP_X_W-1:0] x_i,
  input  logic signed [W-1:0]       add_i  [LANES],
  input  logic        [SIDE_W-1:0]  side_i,
  output logic                      valid_o,
  input  logic                      adv_i,
  output logic signed [W-1:0]       y_o    [LANES],
  output logic        [SIDE_W-1:0]  side_o
);

  localparam int NSL   = (W + HIP_SLICE_W - 1) / HIP_SLICE_W;
  localparam int PAD_W = NSL * HIP_SLICE_W;
  localparam int PP_W  = HIP_SLICE_W + 1 + HIP_X_W;

  logic va_r, vb_r, vc_r;
  logic en_a, en_b, en_c;

  logic        [PAD_W-1:0] a_pad     [LANES];
  logic signed [PP_W-1:0]  pp_nxt    [LANES][NSL];
  logic signed [PP_W-1:0]  pp_r      [LANES][NSL];
  logic signed [W-1:0]     add_a_r   [LANES];
  logic        [SIDE_W-1:0] side_a_r;

  logic signed [W-1:0]     ps_nxt    [LANES];
  logic signed [W-1:0]     ps_r      [LANES];
  logic signed [W-1:0]     add_b_r   [LANES];
  logic        [SIDE_W-1:0] side_b_r;

  logic signed [W-1:0]     y_r       [LANES];
  logic        [SIDE_W-1:0] side_c_r;

  // a stage loads when empty or when its content moves on
  assign en_c  = !vc_r || adv_i;
  assign en_b  = !vb_r || en_c;
  assign en_a  = !va_r || en_b;
  assign adv_o = en_a;

  // every slice, the top one too, is taken as unsigned; the product is kept modulo 2^W
  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      a_pad[l] = PAD_W'(a_i[l]);
      for (int k = 0; k < NSL; k++) begin
        pp_nxt[l][k] = PP_W'($signed({1'b0, a_pad[l][HIP_SLICE_W*k +: HIP_SLICE_W]}))
                       * PP_W'(x_i);
      end
    end
  end

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      ps_nxt[l] = '0;
      for (int k = 0; k < NSL; k++) begin
        ps_nxt[l] = ps_nxt[l] + (W'(pp_r[l][k]) <<< (HIP_SLICE_W * k));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
      vc_r <= 1'b0;
    end else begin
      if (en_a) va_r <= valid_i;
      if (en_b) vb_r <= va_r;
      if (en_c) vc_r <= vb_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en_a) begin
      pp_r     <= pp_nxt;
      add_a_r  <= add_i;
      side_a_r <= side_i;
    end
    if (en_b) begin
      ps_r     <= ps_nxt;
      add_b_r  <= add_a_r;
      side_b_r <= side_a_r;
    end
    if (en_c) begin
      for (int l = 0; l < LANES; l++) y_r[l] <= ps_r[l] + add_b_r[l];
      side_c_r <= side_b_r;
    end
  end

  assign valid_o = vc_r;
  assign y_o     = y_r;
  assign side_o  = side_c_r;

endmodule

// File: rtl/core/heat_index_polynomial.sv
// ----------------------------------------------------------------------------
// heat_index_polynomial
// 16-term heat index polynomial over temperature and humidity samples.
// in_ch carries one sample a beat (temperature, humidity, fixed point),
// out_ch one result a beat (heat_index, saturated). A beat is taken on
// valid and ready both high. Throughput is one beat per cycle when nothing
// stalls. A sample passes an input register, six multiply-accumulate
// steps of three stages each (three Horner steps in humidity on four
// lanes, three in temperature) and the output register. Inputs are
// clamped to -40..150 F and 0..100 %, the sum is floored to the output
// grid and clipped with saturated set.
// Every stage has its own valid bit; a stalled receiver holds the output
// register and the stages behind it fill up, so empty stages still take
// new samples. Reset empties the pipeline and clears out_ch.valid.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module heat_index_polynomial
  import hip_pkg::*;
#(
  parameter int FRACTION_BITS = HIP_FRACTION_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  hip_in_if.sink    in_ch,
  hip_out_if.source out_ch
);

  localparam int W     = HIP_COEF_FRAC + 6 * FRACTION_BITS + HIP_MAG_W;
  localparam int SH    = HIP_COEF_FRAC + 5 * FRACTION_BITS;
  localparam int RES_W = W - SH;
  localparam int T_MIN = HIP_T_LO_DEG * (1 << FRACTION_BITS);
  localparam int T_MAX = HIP_T_HI_DEG * (1 << FRACTION_BITS);
  localparam int H_MAX = HIP_H_HI_PCT * (1 << FRACTION_BITS);
  localparam int HS_W  = 2 * HIP_X_W;
  localparam int TS_W  = HIP_X_W + 2 * W;

  // input register
  logic      v0_r, en0;
  hip_temp_t t_nxt, t0_r;
  hip_hum_t  h_nxt, h0_r;

  always_comb begin
    t_nxt = in_ch.temperature;
    if (int'(in_ch.temperature) < T_MIN) t_nxt = HIP_T_W'(T_MIN);
    else if (int'(in_ch.temperature) > T_MAX) t_nxt = HIP_T_W'(T_MAX);
    h_nxt = in_ch.humidity;
    if (int'(in_ch.humidity) > H_MAX) h_nxt = HIP_H_W'(H_MAX);
  end

  logic h_v   [4];
  logic h_adv [4];
  logic [HS_W-1:0] h_side [4];
  logic signed [W-1:0] h_a   [3][4];
  logic signed [W-1:0] h_add [3][4];
  logic signed [W-1:0] h_y   [3][4];

  assign en0         = !v0_r || h_adv[0];
  assign in_ch.ready = en0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else if (en0) begin
      v0_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en0) begin
      t0_r <= t_nxt;
      h0_r <= h_nxt;
    end
  end

  assign h_v[0]    = v0_r;
  assign h_side[0] = {HIP_X_W'(t0_r), HIP_X_W'(h0_r)};

  // humidity Horner steps, lane i builds sum_j c_ij h^j at a common scale
  for (genvar g = 0; g < 3; g++) begin : g_hstep
    for (genvar i = 0; i < 4; i++) begin : g_lane
      if (g == 0) begin : g_first
        assign h_a[g][i] = W'(hip_coef(2'(i), 2'd3));
      end else begin : g_next
        assign h_a[g][i] = h_y[g-1][i];
      end
      assign h_add[g][i] = W'(hip_coef(2'(i), 2'(2 - g))) <<< ((g + 1) * FRACTION_BITS);
    end

    hip_mac #(
      .LANES  (4),
      .W      (W),
      .SIDE_W (HS_W)
    ) u_hmac (
      .clk     (clk),
      .rst_n   (rst_n),
      .valid_i (h_v[g]),
      .adv_o   (h_adv[g]),
      .a_i     (h_a[g]),
      .x_i     ($signed(h_side[g][HIP_X_W-1:0])),
      .add_i   (h_add[g]),
      .side_i  (h_side[g]),
      .valid_o (h_v[g+1]),
      .adv_i   (h_adv[g+1]),
      .y_o     (h_y[g]),
      .side_o  (h_side[g+1])
    );
  end

  // temperature Horner steps
  logic t1_v, t2_v, t3_v;
  logic t2_adv, t3_adv, en_out;
  logic [TS_W-1:0] t1_side, t1_side_o, t2_side_o;
  logic signed [HIP_X_W-1:0] t1_x, t2_x, t3_x;
  logic signed [W-1:0] t1_a [1], t1_add [1], t1_y [1];
  logic signed [W-1:0] t2_add [1], t2_y [1];
  logic signed [W-1:0] t3_add [1], t3_y [1];

  assign t1_x      = $signed(h_side[3][HS_W-1:HIP_X_W]);
  assign t1_side   = {h_side[3][HS_W-1:HIP_X_W], h_y[2][1], h_y[2][0]};
  assign t1_a[0]   = h_y[2][3];
  assign t1_add[0] = h_y[2][2] <<< FRACTION_BITS;

  hip_mac #(
    .LANES  (1),
    .W      (W),
    .SIDE_W (TS_W)
  ) u_tmac1 (
    .clk     (clk),
    .rst_n   (rst_n),
    .valid_i (h_v[3]),
    .adv_o   (h_adv[3]),
    .a_i     (t1_a),
    .x_i     (t1_x),
    .add_i   (t1_add),
    .side_i  (t1_side),
    .valid_o (t1_v),
    .adv_i   (t2_adv),
    .y_o     (t1_y),
    .side_o  (t1_side_o)
  );

  assign t2_x      = $signed(t1_side_o[TS_W-1 -: HIP_X_W]);
  assign t2_add[0] = $signed(t1_side_o[2*W-1:W]) <<< (2 * FRACTION_BITS);

  hip_mac #(
    .LANES  (1),
    .W      (W),
    .SIDE_W (TS_W)
  ) u_tmac2 (
    .clk     (clk),
    .rst_n   (rst_n),
    .valid_i (t1_v),
    .adv_o   (t2_adv),
    .a_i     (t1_y),
    .x_i     (t2_x),
    .add_i   (t2_add),
    .side_i  (t1_side_o),
    .valid_o (t2_v),
    .adv_i   (t3_adv),
    .y_o     (t2_y),
    .side_o  (t2_side_o)
  );

  assign t3_x      = $signed(t2_side_o[TS_W-1 -: HIP_X_W]);
  assign t3_add[0] = $signed(t2_side_o[W-1:0]) <<< (3 * FRACTION_BITS);

  hip_mac #(
    .LANES  (1),
    .W      (W),
    .SIDE_W (TS_W)
  ) u_tmac3 (
    .clk     (clk),
    .rst_n   (rst_n),
    .valid_i (t2_v),
    .adv_o   (t3_adv),
    .a_i     (t2_y),
    .x_i     (t3_x),
    .add_i   (t3_add),
    .side_i  (t2_side_o),
    .valid_o (t3_v),
    .adv_i   (en_out),
    .y_o     (t3_y),
    .side_o  ()
  );

  // floor to the output grid, then clip
  logic signed [RES_W-1:0] q;
  hip_hi_t hi_nxt, out_hi_r;
  logic    sat_nxt, out_sat_r, out_valid_r;

  always_comb begin
    q       = $signed(t3_y[0][W-1:SH]);
    hi_nxt  = HIP_HI_W'(q);
    sat_nxt = 1'b0;
    if (q > HIP_HI_MAX) begin
      hi_nxt  = HIP_HI_W'(HIP_HI_MAX);
      sat_nxt = 1'b1;
    end else if (q < HIP_HI_MIN) begin
      hi_nxt  = HIP_HI_W'(HIP_HI_MIN);
      sat_nxt = 1'b1;
    end
  end

  assign en_out = !out_valid_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en_out) begin
      out_valid_r <= t3_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en_out) begin
      out_hi_r  <= hi_nxt;
      out_sat_r <= sat_nxt;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.heat_index = out_hi_r;
  assign out_ch.saturated  = out_sat_r;

`ifndef SYNTH
  // a receiver that takes every beat must never hold back the sender
  a_ready_chain: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.ready |-> in_ch.ready)
    else $error("input stalled while output is being drained");

  a_sat_at_limit: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.saturated) |->
      (out_ch.heat_index == HIP_HI_W'(HIP_HI_MAX) ||
       out_ch.heat_index == HIP_HI_W'(HIP_HI_MIN)))
    else $error("saturated flag without a clipped heat index");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> (!out_ch.valid && in_ch.ready))
    else $error("pipeline not empty after reset");
`endif

endmodule
